/* hdl/trp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the three-axis rate PID block.
package trp_pkg;

	localparam int LANES   = 3;   // axis lanes in the payload
	localparam int AXES    = 3;   // axes actually controlled
	localparam int AXIS_W  = 2;   // index width for LANES entries
	localparam int DW      = 16;  // field width
	localparam int GW      = 48;  // packed gain register width
	localparam int APB_DW  = 64;
	localparam int APB_AW  = 6;
	localparam int INT_W   = 32;  // integrator width
	localparam int ACC_W   = 40;  // drive accumulator width
	localparam int ERR_W   = 17;
	localparam int MA_W    = 34;  // multiplier operand A
	localparam int MB_W    = 19;  // multiplier operand B
	localparam int MP_W    = MA_W + MB_W;
	localparam int S_W     = 17;  // fade weight, Q.16, up to 1.0

	localparam logic [DW-1:0] INV_THR_RST = 16'd256;

	typedef enum logic [2:0] {
		REG_PROP,
		REG_INT,
		REG_DERIV,
		REG_FF,
		REG_LIMIT,
		REG_INV_THR
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} seq_state_t;

	// per-axis work steps of the sequencer
	typedef enum logic [3:0] {
		ST_ERR,
		ST_RATIO_MUL,
		ST_RATIO,
		ST_PROP,
		ST_WEIGHT,
		ST_DERIV,
		ST_FF,
		ST_DRIVE,
		ST_TIME,
		ST_INC_MUL,
		ST_INC,
		ST_UPDATE
	} step_t;

	typedef struct packed {
		logic [LANES-1:0][DW-1:0] kp;
		logic [LANES-1:0][DW-1:0] ki;
		logic [LANES-1:0][DW-1:0] kd;
		logic [LANES-1:0][DW-1:0] kf;
		logic [LANES-1:0][DW-1:0] lim;
		logic [DW-1:0]            inv_thr;
	} cfg_t;

endpackage

/* hdl/trp_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces of the rate PID block.
interface trp_in_if;
	import trp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] meas_x;
	logic signed [DW-1:0] meas_y;
	logic signed [DW-1:0] meas_z;
	logic signed [DW-1:0] target_x;
	logic signed [DW-1:0] target_y;
	logic signed [DW-1:0] target_z;
	logic signed [DW-1:0] accel_x;
	logic signed [DW-1:0] accel_y;
	logic signed [DW-1:0] accel_z;
	logic [DW-1:0]        step_time;

	modport source (output valid, meas_x, meas_y, meas_z, target_x, target_y, target_z,
		accel_x, accel_y, accel_z, step_time, input ready);
	modport sink (input valid, meas_x, meas_y, meas_z, target_x, target_y, target_z,
		accel_x, accel_y, accel_z, step_time, output ready);
endinterface

interface trp_out_if;
	import trp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] drive_x;
	logic signed [DW-1:0] drive_y;
	logic signed [DW-1:0] drive_z;

	modport source (output valid, drive_x, drive_y, drive_z, input ready);
	modport sink (input valid, drive_x, drive_y, drive_z, output ready);
endinterface

/* hdl/trp_cfg_regs.sv */
`timescale 1ns / 1ps
// APB register file holding gains, limits and the error threshold reciprocal.
module trp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trp_pkg::APB_AW-1:0]    paddr,
	input  logic [trp_pkg::APB_DW-1:0]    pwdata,
	output logic [trp_pkg::APB_DW-1:0]    prdata,
	output trp_pkg::cfg_t                 cfg
);
	import trp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	// gains and limits clear, threshold reciprocal (lowest field) to 1.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {{(5*GW){1'b0}}, INV_THR_RST};
		end else if (wr) begin
			unique case (idx)
				REG_PROP:    cfg_q.kp      <= pwdata[GW-1:0];
				REG_INT:     cfg_q.ki      <= pwdata[GW-1:0];
				REG_DERIV:   cfg_q.kd      <= pwdata[GW-1:0];
				REG_FF:      cfg_q.kf      <= pwdata[GW-1:0];
				REG_LIMIT:   cfg_q.lim     <= pwdata[GW-1:0];
				REG_INV_THR: cfg_q.inv_thr <= pwdata[DW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP:    prdata = {{(APB_DW-GW){1'b0}}, cfg_q.kp};
			REG_INT:     prdata = {{(APB_DW-GW){1'b0}}, cfg_q.ki};
			REG_DERIV:   prdata = {{(APB_DW-GW){1'b0}}, cfg_q.kd};
			REG_FF:      prdata = {{(APB_DW-GW){1'b0}}, cfg_q.kf};
			REG_LIMIT:   prdata = {{(APB_DW-GW){1'b0}}, cfg_q.lim};
			REG_INV_THR: prdata = {{(APB_DW-DW){1'b0}}, cfg_q.inv_thr};
			default:     prdata = '0;
		endcase
	end

endmodule

/* hdl/trp_mul.sv */
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module trp_mul (
	input  logic                              clk,
	input  logic signed [trp_pkg::MA_W-1:0]   mul_a,
	input  logic signed [trp_pkg::MB_W-1:0]   mul_b,
	output logic signed [trp_pkg::MP_W-1:0]   prod_q
);
	import trp_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

endmodule

/* hdl/trp_core.sv */
`timescale 1ns / 1ps
// Sequencer and datapath: walks each axis through the shared multiplier.
module trp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  trp_pkg::cfg_t cfg,
	trp_in_if.sink        in_ch,
	trp_out_if.source     out_ch
);
	import trp_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

	seq_state_t state_q, state_d;
	step_t      step_q, step_d;
	logic [AXIS_W-1:0] axis_q;
	logic       last_axis, step_end, slot_free;
	logic       in_ready, load_out, run, in_take;
	logic       out_valid_q;

	// request and working registers
	logic signed [DW-1:0]    meas_q [LANES];
	logic signed [DW-1:0]    tgt_q  [LANES];
	logic signed [DW-1:0]    acl_q  [LANES];
	logic [DW-1:0]           dt_q;
	logic signed [INT_W-1:0] integ_q [LANES];
	logic signed [DW-1:0]    drv_q  [LANES];
	logic signed [DW-1:0]    out_q  [LANES];
	logic signed [ERR_W-1:0] err_q;
	logic [17:0]             rabs_q;
	logic                    rbig_q;
	logic [S_W-1:0]          s_q;
	logic signed [MA_W-1:0]  t_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [MP_W-1:0]  prod_q;

	// datapath helpers
	logic signed [INT_W-1:0] integ_cur;
	logic signed [MP_W-1:0]  rmag;
	logic [36:0]             rr_rnd;
	logic signed [ACC_W-1:0] acc_rnd, drv_full;
	logic signed [DW-1:0]    drv_sat;
	logic signed [MP_W-1:0]  t_rnd, inc_rnd;
	logic signed [MA_W+1:0]  nv, lim_pos, integ_new;

	trp_mul u_mul (
		.clk   (clk),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.prod_q(prod_q)
	);

	assign last_axis = (axis_q == AXIS_W'(AXES - 1));
	assign step_end  = (step_q == ST_UPDATE);
	assign slot_free = !out_valid_q || out_ch.ready;
	assign in_take   = in_ch.valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_ch.valid) begin
				state_d = S_RUN;
			end
			S_RUN: if (step_end && last_axis) begin
				state_d = slot_free ? S_IDLE : S_DONE;
			end
			S_DONE: if (slot_free) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		run      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_RUN: begin
				run      = 1'b1;
				load_out = step_end && last_axis && slot_free;
			end
			S_DONE: load_out = slot_free;
			default: ;
		endcase
	end

	always_comb begin
		unique case (step_q)
			ST_ERR:       step_d = ST_RATIO_MUL;
			ST_RATIO_MUL: step_d = ST_RATIO;
			ST_RATIO:     step_d = ST_PROP;
			ST_PROP:      step_d = ST_WEIGHT;
			ST_WEIGHT:    step_d = ST_DERIV;
			ST_DERIV:     step_d = ST_FF;
			ST_FF:        step_d = ST_DRIVE;
			ST_DRIVE:     step_d = ST_TIME;
			ST_TIME:      step_d = ST_INC_MUL;
			ST_INC_MUL:   step_d = ST_INC;
			ST_INC:       step_d = ST_UPDATE;
			ST_UPDATE:    step_d = ST_ERR;
			default:      step_d = ST_ERR;
		endcase
	end

	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.drive_x = out_q[0];
	assign out_ch.drive_y = out_q[1];
	assign out_ch.drive_z = out_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_ERR;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				step_q <= ST_ERR;
				axis_q <= '0;
			end else if (run) begin
				step_q <= step_d;
				if (step_end && !last_axis) begin
					axis_q <= axis_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// multiplier operand select; the product is registered in the multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_RATIO_MUL: begin
				mul_a = MA_W'(err_q);
				mul_b = $signed({{(MB_W-DW){1'b0}}, cfg.inv_thr});
			end
			ST_RATIO: begin
				mul_a = MA_W'(err_q);
				mul_b = MB_W'($signed(cfg.kp[axis_q]));
			end
			ST_PROP: begin
				mul_a = $signed({{(MA_W-18){1'b0}}, rabs_q});
				mul_b = $signed({1'b0, rabs_q});
			end
			ST_WEIGHT: begin
				mul_a = MA_W'(acl_q[axis_q]);
				mul_b = MB_W'($signed(cfg.kd[axis_q]));
			end
			ST_DERIV: begin
				mul_a = MA_W'(tgt_q[axis_q]);
				mul_b = MB_W'($signed(cfg.kf[axis_q]));
			end
			ST_FF: begin
				mul_a = MA_W'(err_q);
				mul_b = MB_W'($signed(cfg.ki[axis_q]));
			end
			ST_DRIVE: begin
				mul_a = prod_q[MA_W-1:0];
				mul_b = $signed({{(MB_W-DW){1'b0}}, dt_q});
			end
			ST_INC_MUL: begin
				mul_a = t_q;
				mul_b = $signed({{(MB_W-S_W){1'b0}}, s_q});
			end
			default: ;
		endcase
	end

	assign integ_cur = integ_q[axis_q];
	assign rmag      = prod_q[MP_W-1] ? -prod_q : prod_q;
	assign rr_rnd    = prod_q[36:0] + 37'(1 << 19);
	assign acc_rnd   = acc_q + ACC_W'(128);
	assign drv_full  = acc_rnd >>> 8;
	assign t_rnd     = prod_q + MP_W'(1 << 15);
	assign inc_rnd   = prod_q + MP_W'(1 << 17);

	always_comb begin
		if (drv_full > SAT_HI) begin
			drv_sat = 16'sh7fff;
		end else if (drv_full < SAT_LO) begin
			drv_sat = 16'sh8000;
		end else begin
			drv_sat = drv_full[DW-1:0];
		end
	end

	// integrator step with symmetric clamp
	assign nv      = (MA_W+2)'(integ_cur) + (MA_W+2)'(t_q);
	assign lim_pos = $signed({{(MA_W+2-DW-6){1'b0}}, cfg.lim[axis_q], 6'b0});
	always_comb begin
		if (nv > lim_pos) begin
			integ_new = lim_pos;
		end else if (nv < -lim_pos) begin
			integ_new = -lim_pos;
		end else begin
			integ_new = nv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				integ_q[i] <= '0;
			end
		end else if (run && step_end) begin
			integ_q[axis_q] <= integ_new[INT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			meas_q[0] <= in_ch.meas_x;
			meas_q[1] <= in_ch.meas_y;
			meas_q[2] <= in_ch.meas_z;
			tgt_q[0]  <= in_ch.target_x;
			tgt_q[1]  <= in_ch.target_y;
			tgt_q[2]  <= in_ch.target_z;
			acl_q[0]  <= in_ch.accel_x;
			acl_q[1]  <= in_ch.accel_y;
			acl_q[2]  <= in_ch.accel_z;
			dt_q      <= in_ch.step_time;
		end
		if (run) begin
			case (step_q)
				ST_ERR: err_q <= ERR_W'(tgt_q[axis_q]) - ERR_W'(meas_q[axis_q]);
				ST_RATIO: begin
					rbig_q <= |rmag[MP_W-1:18];
					rabs_q <= rmag[17:0];
				end
				ST_PROP: acc_q <= prod_q[ACC_W-1:0]
					+ {{(ACC_W-INT_W-2){integ_cur[INT_W-1]}}, integ_cur, 2'b00};
				ST_WEIGHT: s_q <= rbig_q ? '0 : S_W'(1 << 16) - rr_rnd[36:20];
				ST_DERIV:  acc_q <= acc_q - prod_q[ACC_W-1:0];
				ST_FF:     acc_q <= acc_q + prod_q[ACC_W-1:0];
				ST_DRIVE:  drv_q[axis_q] <= drv_sat;
				ST_TIME:   t_q <= t_rnd[MA_W+15:16];
				ST_INC:    t_q <= inc_rnd[MA_W+17:18];
				default: ;
			endcase
		end
		if (load_out) begin
			for (int i = 0; i < LANES; i++) begin
				out_q[i] <= (i < AXES) ? drv_q[i] : '0;
			end
		end
	end

endmodule

/* hdl/three_axis_rate_pid.sv */
`timescale 1ns / 1ps
// Top level of the three-axis rate PID controller.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  in_ch    | in  | valid / ready  | meas_*, target_*, accel_* (Q6.10), step_time
//  out_ch   | out | valid / ready  | drive_x, drive_y, drive_z (Q6.10, saturated)
//  APB      | in  | psel / penable | 64-bit regs at 8*index, pready tied high
//
// Each request is accepted in the idle state and then runs 12 sequencer steps per
// axis, one axis after another; the single shared 34x19 multiplier sets this.
// The integrators reset to zero, gains and limits to zero, the threshold
// reciprocal to 1.0 (256). A new request is taken as soon as the sequencer
// is idle, even while the previous result still waits in the output
// register; a stalled output only holds the sequencer once the next result
// is finished.
module three_axis_rate_pid (
	input  logic                          clk,
	input  logic                          arst_n,
	trp_in_if.sink                        in_ch,
	trp_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [trp_pkg::APB_AW-1:0]    paddr,
	input  logic [trp_pkg::APB_DW-1:0]    pwdata,
	output logic [trp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import trp_pkg::*;

	cfg_t cfg;

	assign pready = 1'b1;

	// register file: writes land on the access phase
	trp_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// sequencer, shared multiplier, integrators and output register
	trp_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// busy right after taking a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("sequencer took a request but did not go busy");

	// a result only appears from a running or waiting sequencer
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(!in_ch.ready))
		else $error("result appeared without a request in flight");

	// threshold register follows an APB write
	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && reg_idx_t'(paddr[APB_AW-1:3]) == REG_INV_THR)
		|=> cfg.inv_thr == $past(pwdata[DW-1:0]))
		else $error("threshold register write lost");

endmodule
